/* rtl/fiv_pkg.sv */
// shared types, constants and the byte-wide crc step for the firmware image verifier
// no dependencies; the input stage, check core and top level import this package
package fiv_pkg;

   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
   localparam logic [31:0] MAGIC_RESET  = 32'hDEADBEEF;

   typedef enum logic [1:0] {
      VERDICT_OK        = 2'd0,
      VERDICT_BAD_MAGIC = 2'd1,
      VERDICT_CRC_FAIL  = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0] image_byte;
      logic       first_byte;
   } req_payload_type;

   typedef struct packed {
      verdict_type verdict;
      logic [31:0] computed_crc;
      logic [31:0] image_version;
      logic [31:0] payload_length;
   } rsp_payload_type;

   // word held in the input register, handed to the check core
   typedef struct packed {
      logic            valid;
      req_payload_type data;
   } stage_type;

   // reflected crc-32, one byte unrolled into eight bit steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

/* rtl/fiv_stream_if.sv */
// valid/ready stream channel with a typed payload
// no dependencies; the payload type is given at instantiation
interface fiv_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/fiv_input_stage.sv */
// input register of the verifier: holds one accepted word until the core takes it
// depends on fiv_pkg and fiv_stream_if
module fiv_input_stage (
   input  logic                clock,
   input  logic                reset,
   fiv_stream_if.sink          req_chan,
   input  logic                advance,
   output fiv_pkg::stage_type  stage
);
   import fiv_pkg::*;

   logic            valid_ff, valid_in;
   req_payload_type data_ff, data_in;
   logic            take;

   // a new word enters whenever the register is empty or drains this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_chan.payload;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;
endmodule

/* rtl/fiv_check_core.sv */
// header parse, crc update and verdict register of the verifier
// depends on fiv_pkg and fiv_stream_if
module fiv_check_core (
   input  logic               clock,
   input  logic               reset,
   input  fiv_pkg::stage_type stage,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   output logic               advance,
   fiv_stream_if.source       rsp_chan
);
   import fiv_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DONE    = 2'd2,
      PH_SPARE   = 2'd3
   } phase_type;

   phase_type       phase_ff, phase_in, cur_phase;
   logic [3:0]      hcount_ff, hcount_in, cur_hcount;
   logic [31:0]     assembly_ff, assembly_in, cur_assembly;
   logic [31:0]     version_ff, version_in, cur_version;
   logic [31:0]     length_ff, length_in, cur_length;
   logic [31:0]     stored_ff, stored_in, cur_stored;
   logic [31:0]     crc_ff, crc_in, cur_crc;
   logic [31:0]     pcount_ff, pcount_in, cur_pcount;
   logic [31:0]     magic_ff, magic_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            emit;
   rsp_payload_type result;
   logic [31:0]     word_new;
   logic [31:0]     crc_next;
   logic [31:0]     pcount_next;
   logic            mark;

   assign advance = stage.valid && (!out_valid_ff || rsp_chan.ready);
   assign mark    = stage.data.first_byte;

   always_comb begin
      // a mark drops all progress before the byte is used
      cur_phase    = mark ? PH_HEADER    : phase_ff;
      cur_hcount   = mark ? 4'd0         : hcount_ff;
      cur_assembly = mark ? 32'd0        : assembly_ff;
      cur_version  = mark ? 32'd0        : version_ff;
      cur_length   = mark ? 32'd0        : length_ff;
      cur_stored   = mark ? 32'd0        : stored_ff;
      cur_crc      = mark ? CRC_ALL_ONES : crc_ff;
      cur_pcount   = mark ? 32'd0        : pcount_ff;

      word_new    = {stage.data.image_byte, cur_assembly[31:8]};
      crc_next    = crc_byte(cur_crc, stage.data.image_byte);
      pcount_next = cur_pcount + 32'd1;

      phase_in    = cur_phase;
      hcount_in   = cur_hcount;
      assembly_in = cur_assembly;
      version_in  = cur_version;
      length_in   = cur_length;
      stored_in   = cur_stored;
      crc_in      = cur_crc;
      pcount_in   = cur_pcount;
      emit        = 1'b0;
      result.verdict        = VERDICT_OK;
      result.computed_crc   = 32'd0;
      result.image_version  = cur_version;
      result.payload_length = cur_length;

      unique case (cur_phase)
         PH_HEADER: begin
            assembly_in = word_new;
            hcount_in   = cur_hcount + 4'd1;
            if (cur_hcount == 4'd3) begin
               if (word_new != magic_ff) begin
                  emit           = 1'b1;
                  phase_in       = PH_DONE;
                  result.verdict = VERDICT_BAD_MAGIC;
               end
            end else if (cur_hcount == 4'd7) begin
               version_in = word_new;
            end else if (cur_hcount == 4'd11) begin
               length_in = word_new;
            end else if (cur_hcount == 4'd15) begin
               stored_in = word_new;
               phase_in  = PH_PAYLOAD;
               pcount_in = 32'd0;
               crc_in    = CRC_ALL_ONES;
               // empty payload: crc of no bytes is zero
               if (cur_length == 32'd0) begin
                  emit           = 1'b1;
                  phase_in       = PH_DONE;
                  result.verdict = (word_new == 32'd0) ? VERDICT_OK : VERDICT_CRC_FAIL;
               end
            end
         end
         PH_PAYLOAD: begin
            crc_in    = crc_next;
            pcount_in = pcount_next;
            if (pcount_next == cur_length) begin
               emit                = 1'b1;
               phase_in            = PH_DONE;
               result.computed_crc = crc_next ^ CRC_ALL_ONES;
               result.verdict      = ((crc_next ^ CRC_ALL_ONES) == cur_stored) ?
                                     VERDICT_OK : VERDICT_CRC_FAIL;
            end
         end
         PH_DONE, PH_SPARE: begin
         end
      endcase
   end

   always_comb begin
      magic_in = csr_wr_en ? csr_wr_data : magic_ff;
      out_in   = out_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hcount_ff    <= 4'd0;
         assembly_ff  <= 32'd0;
         version_ff   <= 32'd0;
         length_ff    <= 32'd0;
         stored_ff    <= 32'd0;
         crc_ff       <= CRC_ALL_ONES;
         pcount_ff    <= 32'd0;
         magic_ff     <= MAGIC_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff    <= phase_in;
            hcount_ff   <= hcount_in;
            assembly_ff <= assembly_in;
            version_ff  <= version_in;
            length_ff   <= length_in;
            stored_ff   <= stored_in;
            crc_ff      <= crc_in;
            pcount_ff   <= pcount_in;
         end
         magic_ff     <= magic_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;
endmodule

/* rtl/firmware_image_verifier_unit.sv */
// top level of the firmware image verifier: input register, check core, csr port
// depends on fiv_pkg, fiv_stream_if, fiv_input_stage and fiv_check_core
//
//   port       dir   word                                   when
//   req_chan   in    image_byte, first_byte                  valid & ready
//   rsp_chan   out   verdict, computed_crc, version, length  valid & ready
//   csr_wr_*   in    expected_magic                          csr_wr_en
//
// one byte per cycle while rsp_chan is not stalled; a byte is held in the input register,
// then the crc step and header decode run combinationally into the result register.
// a verdict is valid on rsp_chan once its last byte has passed both registers.
// a stalled result holds the core, and the input register then fills and drops ready.
// synchronous reset clears progress and loads the magic register with 0xdeadbeef.
module firmware_image_verifier_unit (
   input  logic        clock,
   input  logic        reset,
   fiv_stream_if.sink   req_chan,
   fiv_stream_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import fiv_pkg::*;

   stage_type stage;
   logic      advance;

   fiv_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stage    (stage)
   );

   fiv_check_core u_core (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .rsp_chan    (rsp_chan)
   );
endmodule
